// ----- rtl/core/assert_macros.svh -----
// assertion macros for the mixer rtl, included by jtdm_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/jtdm_pkg.sv -----
// types, widths and constant tables of the tank drive mixer
`default_nettype none

package jtdm_pkg;

   localparam int AXIS_W     = 8;   // joystick axis, signed
   localparam int DRIVE_W    = 8;   // drive percentage, signed
   localparam int CFG_W      = 7;   // configuration register width
   localparam int PADDR_W    = 3;
   localparam int PDATA_W    = 32;
   localparam int CW         = 31;  // cordic x/y datapath, signed
   localparam int ZW         = 26;  // angle accumulator, degrees * 2^16, signed
   localparam int RAD_W      = 32;  // radicand, (x^2 + y^2) << 16
   localparam int REM_W      = 18;  // square root partial remainder
   localparam int ROOT_W     = 16;  // square root result, u8.8
   localparam int MAG_W      = 15;  // clamped magnitude, up to 100.0 in u8.8
   localparam int ANG_W      = 9;   // integer angle 0..359
   localparam int SQRT_STEPS = 16;  // one root bit per cell
   localparam int ATAN_LEN   = 24;

   // atan(2^-i) in degrees * 2^16
   localparam logic signed [ZW-1:0] ATAN_TAB [ATAN_LEN] = '{
      26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
      26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
      26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
      26'sd917,     26'sd458,     26'sd229,    26'sd115,
      26'sd57,      26'sd29,      26'sd14,     26'sd7,
      26'sd4,       26'sd2,       26'sd1,      26'sd0
   };

   // register index, taken from paddr bit 2
   typedef enum logic {
      CSR_DEAD_ZONE = 1'b0,
      CSR_FLOOR     = 1'b1
   } jtdm_csr_type;

   // word handed from cell to cell
   typedef struct packed {
      logic signed [CW-1:0] cx;
      logic signed [CW-1:0] cy;
      logic signed [ZW-1:0] z;
      logic [RAD_W-1:0]     rad;
      logic [REM_W-1:0]     rem;
      logic [ROOT_W-1:0]    root;
      logic                 xneg;   // conditioned x below zero
      logic                 yneg;   // conditioned y below zero
      logic                 swap;   // |y| > |x|, octant mirrored
      logic                 pz;     // minor component zero, angle exactly 0
      logic                 peq;    // components equal, angle exactly 45
   } jtdm_cell_type;

endpackage

`default_nettype wire

// ----- rtl/core/jtdm_channels.sv -----
// valid/ready channel interfaces for joystick samples and drive results
`default_nettype none

interface jtdm_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [jtdm_pkg::AXIS_W-1:0]    axis_x;
   logic signed [jtdm_pkg::AXIS_W-1:0]    axis_y;

   modport source (output valid, output axis_x, output axis_y, input ready);
   modport sink   (input valid, input axis_x, input axis_y, output ready);
endinterface

interface jtdm_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [jtdm_pkg::DRIVE_W-1:0]   left_drive;
   logic signed [jtdm_pkg::DRIVE_W-1:0]   right_drive;

   modport source (output valid, output left_drive, output right_drive, input ready);
   modport sink   (input valid, input left_drive, input right_drive, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/jtdm_front.sv -----
// input conditioning: dead zone, clamp, octant fold and squared length
`default_nettype none

module jtdm_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [jtdm_pkg::CFG_W-1:0]     dead_zone,
   jtdm_req_if.sink                            req,
   output logic                                dn_valid,
   output jtdm_pkg::jtdm_cell_type             dn_data,
   input  wire logic                           dn_ready
);
   import jtdm_pkg::*;

   logic                       va_ff;
   logic signed [AXIS_W-1:0]   xa_ff, ya_ff;
   logic signed [AXIS_W-1:0]   xa_in, ya_in;
   logic                       vb_ff;
   jtdm_cell_type              b_ff, b_in;
   logic                       en_a, en_b;
   logic [6:0]                 ax, ay, px, py;
   logic [13:0]                sx, sy;
   logic [14:0]                sq;

   function automatic logic signed [AXIS_W-1:0] cond_axis(
      input logic signed [AXIS_W-1:0] v,
      input logic [CFG_W-1:0]         dz
   );
      logic [AXIS_W-1:0]        mag;
      logic signed [AXIS_W-1:0] res;
      mag = v[AXIS_W-1] ? AXIS_W'(-v) : AXIS_W'(v);
      if (mag < {1'b0, dz}) begin
         res = '0;
      end else if (v > 8'sd100) begin
         res = 8'sd100;
      end else if (v < -8'sd100) begin
         res = -8'sd100;
      end else begin
         res = v;
      end
      return res;
   endfunction

   assign en_b      = !vb_ff || dn_ready;
   assign en_a      = !va_ff || en_b;
   assign req.ready = en_a;

   always_comb begin
      xa_in = cond_axis(req.axis_x, dead_zone);
      ya_in = cond_axis(req.axis_y, dead_zone);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (en_a) begin
         va_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a && req.valid) begin
         xa_ff <= xa_in;
         ya_ff <= ya_in;
      end
   end

   // fold into the first octant and seed the cell chain
   always_comb begin
      ax = 7'(xa_ff[AXIS_W-1] ? -xa_ff : xa_ff);
      ay = 7'(ya_ff[AXIS_W-1] ? -ya_ff : ya_ff);
      sx = ax * ax;
      sy = ay * ay;
      sq = {1'b0, sx} + {1'b0, sy};
      b_in.swap = ay > ax;
      px = b_in.swap ? ay : ax;
      py = b_in.swap ? ax : ay;
      b_in.cx   = CW'({px, 20'b0});
      b_in.cy   = CW'({py, 20'b0});
      b_in.z    = '0;
      b_in.rad  = {1'b0, sq, 16'b0};
      b_in.rem  = '0;
      b_in.root = '0;
      b_in.xneg = xa_ff[AXIS_W-1];
      b_in.yneg = ya_ff[AXIS_W-1];
      b_in.pz   = py == 7'd0;
      b_in.peq  = py == px;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (en_b) begin
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_b && va_ff) begin
         b_ff <= b_in;
      end
   end

   assign dn_valid = vb_ff;
   assign dn_data  = b_ff;

endmodule

`default_nettype wire

// ----- rtl/core/jtdm_cell.sv -----
// one cell of the chain: a cordic vectoring step (IDX < CORDIC_STAGES) and a square root digit (IDX < 16)
`default_nettype none

module jtdm_cell #(
   parameter int IDX           = 0,
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    up_valid,
   input  jtdm_pkg::jtdm_cell_type      up_data,
   output logic                         up_ready,
   output logic                         dn_valid,
   output jtdm_pkg::jtdm_cell_type      dn_data,
   input  wire logic                    dn_ready
);
   import jtdm_pkg::*;

   localparam bit ROT_EN  = IDX < CORDIC_STAGES;
   localparam bit SQRT_EN = IDX < SQRT_STEPS;
   localparam logic signed [CW-1:0] RND = CW'((64'd1 << IDX) - 64'd1);

   logic                 v_ff;
   jtdm_cell_type        d_ff, d_in;
   logic                 en;
   logic signed [CW-1:0] cxa, cya, dx, dy;
   logic [REM_W+1:0]     rem_sh, trial;

   assign en       = !v_ff || dn_ready;
   assign up_ready = en;

   always_comb begin
      d_in = up_data;
      // shifts truncate toward zero
      cxa = up_data.cx + (up_data.cx[CW-1] ? RND : '0);
      cya = up_data.cy + (up_data.cy[CW-1] ? RND : '0);
      dx  = cya >>> IDX;
      dy  = cxa >>> IDX;
      if (ROT_EN) begin
         if (!up_data.cy[CW-1]) begin
            d_in.cx = up_data.cx + dx;
            d_in.cy = up_data.cy - dy;
            d_in.z  = up_data.z + ATAN_TAB[IDX];
         end else begin
            d_in.cx = up_data.cx - dx;
            d_in.cy = up_data.cy + dy;
            d_in.z  = up_data.z - ATAN_TAB[IDX];
         end
      end
      rem_sh = {up_data.rem, up_data.rad[RAD_W-1 -: 2]};
      trial  = {2'b00, up_data.root, 2'b01};
      if (SQRT_EN) begin
         d_in.rad = {up_data.rad[RAD_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            d_in.rem  = REM_W'(rem_sh - trial);
            d_in.root = {up_data.root[ROOT_W-2:0], 1'b1};
         end else begin
            d_in.rem  = REM_W'(rem_sh);
            d_in.root = {up_data.root[ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en && up_valid) begin
         d_ff <= d_in;
      end
   end

   assign dn_valid = v_ff;
   assign dn_data  = d_ff;

endmodule

`default_nettype wire

// ----- rtl/core/jtdm_back.sv -----
// angle recovery, track factors, drive products and result register
`default_nettype none
`include "assert_macros.svh"

module jtdm_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [jtdm_pkg::CFG_W-1:0]     mag_floor,
   input  wire logic                           up_valid,
   input  jtdm_pkg::jtdm_cell_type             up_data,
   output logic                                up_ready,
   jtdm_rsp_if.source                          rsp
);
   import jtdm_pkg::*;

   localparam logic [23:0]       DEG45  = 24'd2949120;
   localparam logic [23:0]       DEG90  = 24'd5898240;
   localparam logic [23:0]       DEG180 = 24'd11796480;
   localparam logic [ROOT_W-1:0] MAG_MAX = 16'd25600;

   // round(256 * n / 45) for n = 0..45
   localparam logic [8:0] Q28_TAB [46] = '{
      9'd0,   9'd6,   9'd11,  9'd17,  9'd23,  9'd28,  9'd34,  9'd40,
      9'd46,  9'd51,  9'd57,  9'd63,  9'd68,  9'd74,  9'd80,  9'd85,
      9'd91,  9'd97,  9'd102, 9'd108, 9'd114, 9'd119, 9'd125, 9'd131,
      9'd137, 9'd142, 9'd148, 9'd154, 9'd159, 9'd165, 9'd171, 9'd176,
      9'd182, 9'd188, 9'd193, 9'd199, 9'd205, 9'd210, 9'd216, 9'd222,
      9'd228, 9'd233, 9'd239, 9'd245, 9'd250, 9'd256
   };

   logic                       v1_ff, v2_ff, v3_ff, vo_ff;
   logic                       en1, en2, en3, eno;
   logic [MAG_W-1:0]           mag1_ff, mag1_in, mag2_ff;
   logic [ANG_W-1:0]           ang1_ff, ang1_in;
   logic signed [9:0]          fl2_ff, fr2_ff, fl2_in, fr2_in;
   logic signed [25:0]         prod_l_ff, prod_r_ff, prod_l_in, prod_r_in;
   logic signed [DRIVE_W-1:0]  left_ff, right_ff, left_in, right_in;
   logic signed [ZW-1:0]       zc;
   logic [23:0]                oct, q, phi;
   logic [7:0]                 deg;
   logic [MAG_W:0]             floor_mag;

   function automatic logic signed [6:0] left_num(input logic [ANG_W-1:0] a);
      logic signed [10:0] s;
      logic signed [10:0] r;
      s = $signed({2'b00, a});
      if (a <= 9'd90) begin
         r = 11'sd45;
      end else if (a <= 9'd180) begin
         r = 11'sd135 - s;
      end else if (a <= 9'd225) begin
         r = s - 11'sd225;
      end else if (a < 9'd270) begin
         r = 11'sd225 - s;
      end else if (a <= 9'd315) begin
         r = -11'sd45;
      end else begin
         r = (s <<< 1) - 11'sd675;
      end
      return 7'(r);
   endfunction

   // gap after 224 is filled with full reverse
   function automatic logic signed [6:0] right_num(input logic [ANG_W-1:0] a);
      logic signed [10:0] s;
      logic signed [10:0] r;
      s = $signed({2'b00, a});
      if (a == 9'd0) begin
         r = -11'sd45;
      end else if (a < 9'd90) begin
         r = s - 11'sd45;
      end else if (a <= 9'd180) begin
         r = 11'sd45;
      end else if (a < 9'd225) begin
         r = 11'sd405 - (s <<< 1);
      end else if (a <= 9'd270) begin
         r = -11'sd45;
      end else if (a <= 9'd315) begin
         r = s - 11'sd315;
      end else begin
         r = 11'sd315 - s;
      end
      return 7'(r);
   endfunction

   function automatic logic signed [9:0] to_q28(input logic signed [6:0] n);
      logic [5:0] m;
      logic [8:0] r;
      m = 6'(n[6] ? -n : n);
      r = Q28_TAB[m];
      return n[6] ? -$signed({1'b0, r}) : $signed({1'b0, r});
   endfunction

   function automatic logic signed [DRIVE_W-1:0] trunc16(input logic signed [25:0] p);
      logic signed [25:0] adj;
      adj = p + (p[25] ? 26'sd65535 : 26'sd0);
      return DRIVE_W'(adj >>> 16);
   endfunction

   assign eno      = !vo_ff || rsp.ready;
   assign en3      = !v3_ff || eno;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign up_ready = en1;

   // magnitude clamp and integer angle
   always_comb begin
      floor_mag = {1'b0, mag_floor, 8'b0};
      if (up_data.root > MAG_MAX) begin
         mag1_in = MAG_W'(MAG_MAX);
      end else if ({1'b0, up_data.root} < floor_mag) begin
         mag1_in = '0;
      end else begin
         mag1_in = MAG_W'(up_data.root);
      end
      if (up_data.z < 0) begin
         zc = '0;
      end else if (up_data.z > $signed({2'b00, DEG45})) begin
         zc = $signed({2'b00, DEG45});
      end else begin
         zc = up_data.z;
      end
      if (up_data.pz) begin
         oct = '0;
      end else if (up_data.peq) begin
         oct = DEG45;
      end else begin
         oct = 24'(zc);
      end
      q   = up_data.swap ? DEG90 - oct : oct;
      phi = up_data.xneg ? DEG180 - q : q;
      deg = phi[23:16];
      if (up_data.yneg) begin
         ang1_in = {1'b0, deg};
      end else if (deg == 8'd0) begin
         ang1_in = '0;
      end else begin
         ang1_in = 9'd360 - {1'b0, deg};
      end
   end

   always_comb begin
      fl2_in    = to_q28(left_num(ang1_ff));
      fr2_in    = to_q28(right_num(ang1_ff));
      prod_l_in = $signed({1'b0, mag2_ff}) * fl2_ff;
      prod_r_in = $signed({1'b0, mag2_ff}) * fr2_ff;
      left_in   = trunc16(prod_l_ff);
      right_in  = trunc16(prod_r_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= up_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
         if (eno) begin
            vo_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && up_valid) begin
         mag1_ff <= mag1_in;
         ang1_ff <= ang1_in;
      end
      if (en2 && v1_ff) begin
         mag2_ff <= mag1_ff;
         fl2_ff  <= fl2_in;
         fr2_ff  <= fr2_in;
      end
      if (en3 && v2_ff) begin
         prod_l_ff <= prod_l_in;
         prod_r_ff <= prod_r_in;
      end
      if (eno && v3_ff) begin
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   assign rsp.valid       = vo_ff;
   assign rsp.left_drive  = left_ff;
   assign rsp.right_drive = right_ff;

   `ASSERT_IMPLIES(a_ang_range, clock, reset, v1_ff, ang1_ff < 9'd360, "angle beyond 359")
   `ASSERT_NEXT(a_prod_hold, clock, reset, v3_ff && vo_ff && !rsp.ready, v3_ff && $stable(prod_l_ff) && $stable(prod_r_ff), "stalled product lost")
   `ASSERT_IMPLIES(a_drive_range, clock, reset, vo_ff, (left_ff <= 8'sd100) && (left_ff >= -8'sd100) && (right_ff <= 8'sd100) && (right_ff >= -8'sd100), "drive beyond 100 percent")

endmodule

`default_nettype wire

// ----- rtl/core/joystick_tank_drive_mixer.sv -----
// top level of the joystick tank drive mixer
`default_nettype none

// Joystick tank drive mixer. Each beat on req_if carries one joystick sample
// (axis_x, axis_y); each beat on rsp_if carries the matching left and right
// track drive in percent, -100..100, one result per sample and in order.
// Each axis gets a dead zone (axis_dead_zone, reset 10) and a clamp to +-100.
// The vector length is a truncated u8.8 square root, clamped to 100.0 and
// forced to zero below magnitude_floor (reset 20); zero length gives zero
// drive. The heading -atan2(y, x) is found by a cordic in the first octant,
// truncated to whole degrees and wrapped to 0..359; two piecewise-linear
// curves of it give Q2.8 track factors that scale the length.
// Rate: one sample per clock while results are taken. An accepted sample
// passes two input stages, a chain of N = max(CORDIC_STAGES, 16) cells
// (each doing a cordic rotation if its index is below CORDIC_STAGES, a root
// digit if below 16) and four output stages. A stalled result stalls only
// the stages behind it that are full, so empty slots keep accepting.
// No clearing pass after reset. Registers sit at byte 0 (axis_dead_zone) and 4
// (magnitude_floor), 7 bits each, read back over the same port; write them
// only while no sample is in flight.

module joystick_tank_drive_mixer #(
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   jtdm_req_if.sink                               req_if,
   jtdm_rsp_if.source                             rsp_if,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [jtdm_pkg::PADDR_W-1:0]      csr_paddr,
   input  wire logic [jtdm_pkg::PDATA_W-1:0]      csr_pwdata,
   output logic [jtdm_pkg::PDATA_W-1:0]           csr_prdata,
   output logic                                   csr_pready
);
   import jtdm_pkg::*;

   // chain length covers both the cordic and the 16 root digits
   localparam int NCELL = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;

   localparam logic [CFG_W-1:0] DEAD_ZONE_RST = 7'd10;
   localparam logic [CFG_W-1:0] FLOOR_RST     = 7'd20;

   logic [CFG_W-1:0]  dead_zone_ff;
   logic [CFG_W-1:0]  floor_ff;
   logic              csr_wr;
   jtdm_csr_type      csr_sel;

   // hand-off between front, cells and back
   logic              c_vld [NCELL+1];
   logic              c_rdy [NCELL+1];
   jtdm_cell_type     c_dat [NCELL+1];

   // configuration port: every access completes at once
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_sel    = jtdm_csr_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff <= DEAD_ZONE_RST;
         floor_ff     <= FLOOR_RST;
      end else if (csr_wr) begin
         case (csr_sel)
            CSR_DEAD_ZONE: dead_zone_ff <= csr_pwdata[CFG_W-1:0];
            CSR_FLOOR:     floor_ff     <= csr_pwdata[CFG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         CSR_DEAD_ZONE: csr_prdata = PDATA_W'(dead_zone_ff);
         CSR_FLOOR:     csr_prdata = PDATA_W'(floor_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // dead zone, clamp, octant fold, squared length
   jtdm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .dead_zone (dead_zone_ff),
      .req       (req_if),
      .dn_valid  (c_vld[0]),
      .dn_data   (c_dat[0]),
      .dn_ready  (c_rdy[0])
   );

   // row of cells, each hands its word to the next every cycle it may
   for (genvar k = 0; k < NCELL; k++) begin : g_cell
      jtdm_cell #(
         .IDX           (k),
         .CORDIC_STAGES (CORDIC_STAGES)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (c_vld[k]),
         .up_data  (c_dat[k]),
         .up_ready (c_rdy[k]),
         .dn_valid (c_vld[k+1]),
         .dn_data  (c_dat[k+1]),
         .dn_ready (c_rdy[k+1])
      );
   end

   // angle, factors, products and the result register
   jtdm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mag_floor (floor_ff),
      .up_valid  (c_vld[NCELL]),
      .up_data   (c_dat[NCELL]),
      .up_ready  (c_rdy[NCELL]),
      .rsp       (rsp_if)
   );

endmodule

`default_nettype wire
